>>> sv/tspes_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspes_pkg
// Shared types, constants and helpers of the transport-stream PES packetizer.
// ----------------------------------------------------------------------------
package tspes_pkg;

   localparam logic [7:0] TS_SYNC       = 8'h47;
   localparam logic [7:0] TS_BODY_BYTES = 8'd184;
   localparam logic [7:0] TS_PKT_BYTES  = 8'd188;
   localparam logic [5:0] TS_LAST_WORD  = 6'd46;
   localparam logic [7:0] AF_KEY_FLAGS  = 8'h50;
   localparam logic [6:0] PCR_RESERVED  = 7'h7e;
   localparam logic [7:0] STUFF_BYTE    = 8'hff;
   localparam logic [7:0] PES_MARKER    = 8'h80;
   localparam logic [7:0] AF_KEY_BYTES  = 8'd8;
   localparam logic [7:0] PES_LEN_PTS   = 8'd14;
   localparam logic [7:0] PES_LEN_BOTH  = 8'd19;
   localparam logic [7:0] HSIZE_PTS     = 8'd5;
   localparam logic [7:0] HSIZE_BOTH    = 8'd10;

   localparam logic [12:0] VIDEO_PID_RESET = 13'h100;
   localparam logic [12:0] AUDIO_PID_RESET = 13'h101;
   localparam logic [7:0]  VIDEO_SID_RESET = 8'he0;
   localparam logic [7:0]  AUDIO_SID_RESET = 8'hc0;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 33;
   localparam logic [2:0] CSR_VIDEO_PID = 3'd0;
   localparam logic [2:0] CSR_AUDIO_PID = 3'd1;
   localparam logic [2:0] CSR_VIDEO_SID = 3'd2;
   localparam logic [2:0] CSR_AUDIO_SID = 3'd3;
   localparam logic [2:0] CSR_TS_DELAY  = 3'd4;

   typedef struct packed {
      logic [12:0] video_pid;
      logic [12:0] audio_pid;
      logic [7:0]  video_sid;
      logic [7:0]  audio_sid;
      logic [32:0] delay;
   } cfg_type;

   // One request as the back end sees it: the payload byte and, when it opens
   // a packet, everything needed to build that packet's header.
   typedef struct packed {
      logic [7:0]  payload;
      logic        hdr;
      logic        first;
      logic        key;
      logic        dts_ne;
      logic        stream;
      logic [3:0]  cc;
      logic        has_af;
      logic [7:0]  af_len;
      logic [7:0]  pes_start;
      logic [7:0]  hdr_len;
      logic [15:0] psize;
      logic [32:0] pts_t;
      logic [32:0] dts_t;
      logic [32:0] pcr;
   } cmd_type;

   localparam int CMD_BITS = $bits(cmd_type);
   localparam int OUT_BITS = 33;

   function automatic logic [7:0] stamp_byte(input logic [3:0] fb,
                                             input logic [32:0] t,
                                             input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0: b = {fb, t[32:30], 1'b1};
         3'd1: b = t[29:22];
         3'd2: b = {t[21:15], 1'b1};
         3'd3: b = t[14:7];
         3'd4: b = {t[6:0], 1'b1};
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

>>> sv/tspes_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspes_fifo
// Small synchronous queue with the oldest entry shown at its output.
// ----------------------------------------------------------------------------
module tspes_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]      cnt_ff, cnt_in;
   logic             do_push, do_pop;

   always_comb begin
      full    = (cnt_ff == (AW+1)'(DEPTH));
      empty   = (cnt_ff == '0);
      rdata   = mem_ff[rd_ff];
      do_push = push && !full;
      do_pop  = pop && !empty;
      wr_in   = wr_ff;
      rd_in   = rd_ff;
      cnt_in  = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= wdata;
      end
   end

endmodule

>>> sv/tspes_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspes_front
// Accepts payload bytes, tracks frame and packet position, and plans headers.
// ----------------------------------------------------------------------------
module tspes_front #(
   parameter int LENGTH_BITS = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic [7:0]               payload_byte,
   input  logic                     frame_start,
   input  logic                     stream_select,
   input  logic                     keyframe,
   input  logic [32:0]              pts,
   input  logic [32:0]              dts,
   input  logic [23:0]              frame_length,
   input  tspes_pkg::cfg_type       cfg,
   input  logic                     cmd_full,
   output logic                     cmd_push,
   output tspes_pkg::cmd_type       cmd
);
   import tspes_pkg::*;

   logic [LENGTH_BITS-1:0] rem_ff, rem_in;
   logic [7:0]             pos_ff, pos_in;
   logic                   cur_ff, cur_in;
   logic [1:0][3:0]        cc_ff, cc_in;

   logic [LENGTH_BITS-1:0] len, rem_eff;
   logic [LENGTH_BITS:0]   psum;
   logic                   accept, keep, first, stream, key, hdr, dts_ne, short_pkt;
   logic                   has_af;
   logic [7:0]             pos_eff, pes_len, afk, body, stuff, af_len, pes_start;
   logic [7:0]             hdr_len, hsize, pos_step;
   logic [3:0]             cc_new;

   always_comb begin
      accept  = push && !cmd_full;
      len     = LENGTH_BITS'(frame_length);
      first   = (rem_ff == '0);
      keep    = !first || (frame_start && (len != '0));
      stream  = first ? stream_select : cur_ff;
      key     = first && keyframe;
      rem_eff = first ? len : rem_ff;
      pos_eff = first ? 8'd0 : pos_ff;
      hdr     = (pos_eff == 8'd0);
      dts_ne  = (pts != dts);
      pes_len = first ? (dts_ne ? PES_LEN_BOTH : PES_LEN_PTS) : 8'd0;
      afk     = key ? AF_KEY_BYTES : 8'd0;
      body    = TS_BODY_BYTES - afk - pes_len;
      short_pkt = (rem_eff < LENGTH_BITS'(body));
      stuff   = short_pkt ? (body - rem_eff[7:0]) : 8'd0;
      has_af  = key || short_pkt;
      // A keyless field of one stuffing byte is just the length byte set to zero.
      if (key) begin
         af_len = 8'd7 + stuff;
      end else if (stuff >= 8'd2) begin
         af_len = stuff - 8'd1;
      end else begin
         af_len = 8'd0;
      end
      pes_start = 8'd4 + (has_af ? af_len + 8'd1 : 8'd0);
      hdr_len   = pes_start + pes_len;
      pos_step  = hdr ? hdr_len + 8'd1 : pos_eff + 8'd1;
      pos_in    = (pos_step == TS_PKT_BYTES) ? 8'd0 : pos_step;
      cc_new    = cc_ff[stream] + 4'd1;
      hsize     = dts_ne ? HSIZE_BOTH : HSIZE_PTS;
      psum      = {1'b0, rem_eff} + (LENGTH_BITS+1)'(hsize) + (LENGTH_BITS+1)'(3);

      rem_in = rem_eff - 1'b1;
      cur_in = stream;
      cc_in  = cc_ff;
      if (hdr) begin
         cc_in[stream] = cc_new;
      end

      cmd_push      = accept && keep;
      cmd.payload   = payload_byte;
      cmd.hdr       = hdr;
      cmd.first     = first;
      cmd.key       = key;
      cmd.dts_ne    = dts_ne;
      cmd.stream    = stream;
      cmd.cc        = cc_new;
      cmd.has_af    = has_af;
      cmd.af_len    = af_len;
      cmd.pes_start = pes_start;
      cmd.hdr_len   = hdr ? hdr_len : 8'd0;
      cmd.psize     = (psum > (LENGTH_BITS+1)'(16'hffff)) ? 16'd0 : psum[15:0];
      cmd.pts_t     = pts + cfg.delay;
      cmd.dts_t     = dts + cfg.delay;
      cmd.pcr       = dts - cfg.delay;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
         pos_ff <= '0;
         cur_ff <= 1'b0;
         cc_ff  <= '0;
      end else if (cmd_push) begin
         rem_ff <= rem_in;
         pos_ff <= pos_in;
         cur_ff <= cur_in;
         cc_ff  <= cc_in;
      end
   end

endmodule

>>> sv/tspes_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspes_back
// Emits header and payload bytes one a cycle unless stalled, packed as words.
// ----------------------------------------------------------------------------
module tspes_back (
   input  logic               clock,
   input  logic               reset,
   input  tspes_pkg::cfg_type cfg,
   input  logic               cmd_valid,
   input  tspes_pkg::cmd_type cmd,
   output logic               cmd_pop,
   input  logic               out_full,
   output logic               out_push,
   output logic [31:0]        out_word,
   output logic               out_end
);
   import tspes_pkg::*;

   logic [7:0]  k_ff, k_in;
   logic [23:0] wa_ff, wa_in;
   logic [1:0]  biw_ff, biw_in;
   logic [5:0]  wcnt_ff, wcnt_in;

   logic        go, in_hdr;
   logic [7:0]  hbyte, obyte, j, p;
   logic [12:0] pid;
   logic [7:0]  sid;

   always_comb begin
      pid = cmd.stream ? cfg.audio_pid : cfg.video_pid;
      sid = cmd.stream ? cfg.audio_sid : cfg.video_sid;
      j   = k_ff - 8'd5;
      p   = k_ff - cmd.pes_start;
      if (k_ff == 8'd0) begin
         hbyte = TS_SYNC;
      end else if (k_ff == 8'd1) begin
         hbyte = {1'b0, cmd.first, 1'b0, pid[12:8]};
      end else if (k_ff == 8'd2) begin
         hbyte = pid[7:0];
      end else if (k_ff == 8'd3) begin
         hbyte = {2'b00, cmd.has_af, 1'b1, cmd.cc};
      end else if (k_ff == 8'd4 && cmd.has_af) begin
         hbyte = cmd.af_len;
      end else if (k_ff < cmd.pes_start) begin
         if (cmd.key) begin
            case (j)
               8'd0: hbyte = AF_KEY_FLAGS;
               8'd1: hbyte = cmd.pcr[32:25];
               8'd2: hbyte = cmd.pcr[24:17];
               8'd3: hbyte = cmd.pcr[16:9];
               8'd4: hbyte = cmd.pcr[8:1];
               8'd5: hbyte = {cmd.pcr[0], PCR_RESERVED};
               8'd6: hbyte = 8'h00;
               default: hbyte = STUFF_BYTE;
            endcase
         end else begin
            hbyte = (j == 8'd0) ? 8'h00 : STUFF_BYTE;
         end
      end else begin
         case (p)
            8'd0, 8'd1: hbyte = 8'h00;
            8'd2: hbyte = 8'h01;
            8'd3: hbyte = sid;
            8'd4: hbyte = cmd.psize[15:8];
            8'd5: hbyte = cmd.psize[7:0];
            8'd6: hbyte = PES_MARKER;
            8'd7: hbyte = {1'b1, cmd.dts_ne, 6'b0};
            8'd8: hbyte = cmd.dts_ne ? HSIZE_BOTH : HSIZE_PTS;
            8'd9, 8'd10, 8'd11, 8'd12, 8'd13:
               hbyte = stamp_byte({2'b00, 1'b1, cmd.dts_ne}, cmd.pts_t, 3'(p - 8'd9));
            8'd14, 8'd15, 8'd16, 8'd17, 8'd18:
               hbyte = stamp_byte(4'd1, cmd.dts_t, 3'(p - 8'd14));
            default: hbyte = 8'h00;
         endcase
      end

      in_hdr  = cmd.hdr && (k_ff < cmd.hdr_len);
      obyte   = in_hdr ? hbyte : cmd.payload;
      go      = cmd_valid && !out_full;
      cmd_pop = go && !in_hdr;
      k_in    = in_hdr ? k_ff + 8'd1 : 8'd0;

      out_push = go && (biw_ff == 2'd3);
      out_word = {wa_ff, obyte};
      out_end  = (wcnt_ff == TS_LAST_WORD);
      wa_in    = {wa_ff[15:0], obyte};
      biw_in   = biw_ff + 2'd1;
      wcnt_in  = wcnt_ff;
      if (out_push) begin
         wcnt_in = out_end ? 6'd0 : wcnt_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff    <= '0;
         biw_ff  <= '0;
         wcnt_ff <= '0;
      end else if (go) begin
         k_ff    <= k_in;
         biw_ff  <= biw_in;
         wcnt_ff <= wcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         wa_ff <= wa_in;
      end
   end

endmodule

>>> sv/ts_pes_packetizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ts_pes_packetizer_top
// Cuts elementary-stream frames into 188-byte transport packets of 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter one payload byte at a time through req_push / req_full; the
//   frame fields ride along with the first byte of a frame. Packet words leave
//   through rsp_empty / rsp_pop, first packet byte in bits 31..24, with
//   rsp_packet_end set on the 47th word of each packet.
//   The front end takes one request per cycle while its two-entry queue has
//   room. The back end emits one byte at a time and waits while the output
//   queue is full: a request that does not open a packet gives its payload
//   byte alone, one that opens a packet gives its 4 to 187 header bytes
//   first. A word shows on rsp_* in the cycle after the back end produces
//   its last byte.
//   When the receiver stalls, the two-entry output queue fills, the back end
//   waits, and req_full rises once the request queue is full; nothing is lost.
//   Reset empties both queues, clears the frame state and continuity
//   counters, and loads the default PIDs, stream ids and a zero delay.
//   CSR writes take effect at once and belong in idle periods only.
// ----------------------------------------------------------------------------
module ts_pes_packetizer_top #(
   parameter int LENGTH_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_payload_byte,
   input  logic        req_frame_start,
   input  logic        req_stream_select,
   input  logic        req_keyframe,
   input  logic [32:0] req_pts,
   input  logic [32:0] req_dts,
   input  logic [23:0] req_frame_length,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_out_word,
   output logic        rsp_packet_end,
   input  logic        csr_we,
   input  logic [tspes_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [tspes_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import tspes_pkg::*;

   cfg_type cfg_ff;
   cmd_type cmd_w, cmd_r;
   logic    cmd_push, cmd_full, cmd_empty, cmd_pop;
   logic    out_push, out_full, out_end;
   logic [31:0] out_word;
   logic [OUT_BITS-1:0] out_r;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.video_pid <= VIDEO_PID_RESET;
         cfg_ff.audio_pid <= AUDIO_PID_RESET;
         cfg_ff.video_sid <= VIDEO_SID_RESET;
         cfg_ff.audio_sid <= AUDIO_SID_RESET;
         cfg_ff.delay     <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_VIDEO_PID: cfg_ff.video_pid <= csr_wdata[12:0];
            CSR_AUDIO_PID: cfg_ff.audio_pid <= csr_wdata[12:0];
            CSR_VIDEO_SID: cfg_ff.video_sid <= csr_wdata[7:0];
            CSR_AUDIO_SID: cfg_ff.audio_sid <= csr_wdata[7:0];
            CSR_TS_DELAY:  cfg_ff.delay     <= csr_wdata[32:0];
            default: ;
         endcase
      end
   end

   tspes_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (req_push),
      .payload_byte  (req_payload_byte),
      .frame_start   (req_frame_start),
      .stream_select (req_stream_select),
      .keyframe      (req_keyframe),
      .pts           (req_pts),
      .dts           (req_dts),
      .frame_length  (req_frame_length),
      .cfg           (cfg_ff),
      .cmd_full      (cmd_full),
      .cmd_push      (cmd_push),
      .cmd           (cmd_w)
   );

   assign req_full = cmd_full;

   tspes_fifo #(.WIDTH(CMD_BITS), .DEPTH(2)) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata (cmd_w),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .rdata (cmd_r),
      .empty (cmd_empty)
   );

   tspes_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (!cmd_empty),
      .cmd       (cmd_r),
      .cmd_pop   (cmd_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_word  (out_word),
      .out_end   (out_end)
   );

   tspes_fifo #(.WIDTH(OUT_BITS), .DEPTH(2)) u_out_q (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata ({out_end, out_word}),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (out_r),
      .empty (rsp_empty)
   );

   assign rsp_out_word   = out_r[31:0];
   assign rsp_packet_end = out_r[32];

endmodule

>>> sv/tspes_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspes_checker
// Port-level checks on the packet word stream of the packetizer.
// ----------------------------------------------------------------------------
module tspes_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [31:0] rsp_out_word,
   input logic        rsp_packet_end
);
   logic [5:0] wcnt_ff, wcnt_in;
   logic       take;

   always_comb begin
      take    = rsp_pop && !rsp_empty;
      wcnt_in = wcnt_ff;
      if (take) begin
         wcnt_in = (wcnt_ff == 6'd46) ? 6'd0 : wcnt_ff + 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wcnt_ff <= '0;
      end else begin
         wcnt_ff <= wcnt_in;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("response queue not empty after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_out_word)
                                    && $stable(rsp_packet_end)))
      else $error("waiting response changed");

   a_end_cadence: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_packet_end == (wcnt_ff == 6'd46)))
      else $error("packet end not on the 47th word");

   a_sync: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && wcnt_ff == 6'd0) |-> (rsp_out_word[31:24] == 8'h47))
      else $error("packet does not open with the sync byte");

endmodule

bind ts_pes_packetizer_top tspes_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_empty      (rsp_empty),
   .rsp_pop        (rsp_pop),
   .rsp_out_word   (rsp_out_word),
   .rsp_packet_end (rsp_packet_end)
);

>>> dv/tb_ts_pes_packetizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ts_pes_packetizer_top
// Self-checking bench for the transport-stream PES packetizer.
// ----------------------------------------------------------------------------
// Payload-byte requests are pushed through the request queue while a packet
// model inside the bench builds the expected 32-bit packet words. Every word
// popped from the block is compared with the oldest expected word. A short
// table of directed requests comes first, followed by random frames under
// several register settings, random idling on both sides, a long receiver
// stall and a final frame too long for the PES length field.
// ----------------------------------------------------------------------------
module tb_ts_pes_packetizer_top;
   import tspes_pkg::*;

   localparam logic [2:0] CSR_SPARE_INDEX = 3'd7;
   localparam int         PKT_BYTES       = 188;

   typedef struct {
      logic [7:0]  pay;
      logic        st;
      logic        sel;
      logic        key;
      logic [32:0] pts;
      logic [32:0] dts;
      logic [23:0] len;
      logic        chk;
      logic [31:0] first_word;
   } req_type;

   typedef struct {
      logic [31:0] word;
      logic        last;
   } pkt_word_type;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [7:0]  req_payload_byte;
   logic        req_frame_start;
   logic        req_stream_select;
   logic        req_keyframe;
   logic [32:0] req_pts;
   logic [32:0] req_dts;
   logic [23:0] req_frame_length;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [31:0] rsp_out_word;
   logic        rsp_packet_end;
   logic        csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   ts_pes_packetizer_top uut (.*);

   // Packet model state.
   logic [12:0] pid_by_stream [2];
   logic [7:0]  sid_by_stream [2];
   logic [32:0] stamp_delay;
   logic [3:0]  cont_count [2];
   int unsigned pkt_pos;
   logic [23:0] frame_left;
   logic        frame_stream;
   logic [23:0] word_bytes;
   int unsigned word_fill;

   pkt_word_type expected_words [$];
   int errors, words_checked, requests_sent, frames_sent, csr_writes;
   bit idle_en;
   bit hold_req;
   int hold_left;

   always begin
      clock = 1'b1; #4;
      clock = 1'b0; #4;
   end

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %0t: %s got %h expected %h", $time, what, got, want);
      errors++;
   endtask

   task automatic emit_byte(input logic [7:0] b);
      pkt_word_type pw;
      pkt_pos++;
      if (word_fill == 3) begin
         pw.word = {word_bytes, b};
         pw.last = (pkt_pos >= PKT_BYTES);
         expected_words.push_back(pw);
         if (pkt_pos >= PKT_BYTES) pkt_pos = 0;
         word_bytes = '0;
         word_fill = 0;
      end else begin
         word_bytes = {word_bytes[15:0], b};
         word_fill++;
      end
   endtask

   function automatic logic [39:0] stamp_field(input logic [3:0] fb, input logic [32:0] t);
      return {fb, t[32:30], 1'b1, t[29:22], t[21:15], 1'b1, t[14:7], t[6:0], 1'b1};
   endfunction

   // Works out the packet words that one accepted request produces.
   task automatic packetize_request(input req_type r);
      logic [7:0]  af [0:PKT_BYTES-1];
      logic [7:0]  pes [0:23];
      int          af_n, pes_n, body, stuff, i;
      logic        first, key, has_af, two_stamps;
      logic [12:0] pid;
      logic [3:0]  cc;
      logic [32:0] pcr;
      logic [31:0] psize;
      logic [7:0]  hsize, flags;
      logic [39:0] st;
      first = 1'b0;
      key = 1'b0;
      if (frame_left == 0) begin
         if (!r.st || r.len == 0) return;
         frame_stream = r.sel;
         key = r.key;
         frame_left = r.len;
         first = 1'b1;
         pkt_pos = 0;
         word_bytes = '0;
         word_fill = 0;
         frames_sent++;
      end
      if (pkt_pos == 0) begin
         af_n = 0;
         pes_n = 0;
         has_af = 1'b0;
         pid = pid_by_stream[frame_stream];
         cc = cont_count[frame_stream] + 4'd1;
         cont_count[frame_stream] = cc;
         if (first) begin
            two_stamps = (r.dts != r.pts);
            if (key) begin
               pcr = r.dts - stamp_delay;
               has_af = 1'b1;
               af[0] = AF_KEY_FLAGS;
               af[1] = pcr[32:25];
               af[2] = pcr[24:17];
               af[3] = pcr[16:9];
               af[4] = pcr[8:1];
               af[5] = {pcr[0], PCR_RESERVED};
               af[6] = 8'h00;
               af_n = 7;
            end
            hsize = two_stamps ? 8'd10 : 8'd5;
            flags = two_stamps ? 8'hc0 : 8'h80;
            psize = 32'(frame_left) + hsize + 3;
            if (psize > 32'hffff) psize = 0;
            pes[0] = 8'h00; pes[1] = 8'h00; pes[2] = 8'h01;
            pes[3] = sid_by_stream[frame_stream];
            pes[4] = psize[15:8];
            pes[5] = psize[7:0];
            pes[6] = PES_MARKER;
            pes[7] = flags;
            pes[8] = hsize;
            st = stamp_field({2'b00, flags[7:6]}, r.pts + stamp_delay);
            for (i = 0; i < 5; i++) pes[9 + i] = st[39 - 8*i -: 8];
            pes_n = 14;
            if (two_stamps) begin
               st = stamp_field(4'd1, r.dts + stamp_delay);
               for (i = 0; i < 5; i++) pes[14 + i] = st[39 - 8*i -: 8];
               pes_n = 19;
            end
         end
         body = 184 - (has_af ? 1 + af_n : 0) - pes_n;
         if (int'(frame_left) < body) begin
            stuff = body - int'(frame_left);
            if (has_af) begin
               for (i = 0; i < stuff; i++) af[af_n++] = STUFF_BYTE;
            end else begin
               has_af = 1'b1;
               if (stuff >= 2) begin
                  af[af_n++] = 8'h00;
                  for (i = 0; i + 2 < stuff; i++) af[af_n++] = STUFF_BYTE;
               end
            end
         end
         emit_byte(TS_SYNC);
         emit_byte({first ? 3'b010 : 3'b000, pid[12:8]});
         emit_byte(pid[7:0]);
         emit_byte({2'b00, has_af, 1'b1, cc});
         if (has_af) begin
            emit_byte(8'(af_n));
            for (i = 0; i < af_n; i++) emit_byte(af[i]);
         end
         for (i = 0; i < pes_n; i++) emit_byte(pes[i]);
      end
      emit_byte(r.pay);
      frame_left = frame_left - 24'd1;
   endtask

   task automatic send_request(input req_type r);
      int queued;
      while (idle_en && $urandom_range(99) < 15) begin
         @(negedge clock) req_push <= 1'b0;
         @(posedge clock);
      end
      @(negedge clock);
      req_push <= 1'b1;
      req_payload_byte <= r.pay;
      req_frame_start <= r.st;
      req_stream_select <= r.sel;
      req_keyframe <= r.key;
      req_pts <= r.pts;
      req_dts <= r.dts;
      req_frame_length <= r.len;
      do @(posedge clock); while (req_full);
      queued = expected_words.size();
      packetize_request(r);
      requests_sent++;
      if (r.chk && expected_words.size() > queued && expected_words[queued].word != r.first_word)
         report("header word", expected_words[queued].word, r.first_word);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [32:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      csr_writes++;
      case (idx)
         CSR_VIDEO_PID: pid_by_stream[0] = data[12:0];
         CSR_AUDIO_PID: pid_by_stream[1] = data[12:0];
         CSR_VIDEO_SID: sid_by_stream[0] = data[7:0];
         CSR_AUDIO_SID: sid_by_stream[1] = data[7:0];
         CSR_TS_DELAY:  stamp_delay = data;
         default: ;
      endcase
   endtask

   task automatic drain();
      @(negedge clock) req_push <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (250) @(posedge clock);
   endtask

   function automatic logic [32:0] rand33();
      return {1'($urandom_range(1)), $urandom};
   endfunction

   function automatic req_type rand_fields(input logic st);
      req_type r;
      r.pay = 8'($urandom);
      r.st = st;
      r.sel = 1'($urandom_range(1));
      r.key = 1'($urandom_range(1));
      r.pts = rand33();
      r.dts = $urandom_range(1) ? r.pts : rand33();
      r.len = 24'($urandom);
      r.chk = 1'b0;
      r.first_word = '0;
      return r;
   endfunction

   // Mostly whole frames with random content; some stray bytes and empty starts.
   task automatic random_frames(input int count);
      int target, sel, i;
      req_type r;
      target = requests_sent + count;
      while (requests_sent < target) begin
         sel = $urandom_range(99);
         if (sel < 5) begin
            send_request(rand_fields(1'b0));
         end else if (sel < 10) begin
            r = rand_fields(1'b1);
            r.len = '0;
            send_request(r);
         end else begin
            r = rand_fields(1'b1);
            r.len = 24'(($urandom_range(9) == 0) ? $urandom_range(171, 230)
                                                 : $urandom_range(1, 60));
            send_request(r);
            for (i = 1; i < r.len; i++)
               send_request(rand_fields($urandom_range(19) == 0));
         end
      end
   endtask

   always @(negedge clock) begin
      if (hold_req) begin
         hold_req = 1'b0;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= !(idle_en && $urandom_range(99) < 15);
      end
   end

   always @(posedge clock) begin
      pkt_word_type pw;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_words.size() == 0) begin
            report("unexpected word", rsp_out_word, '0);
         end else begin
            pw = expected_words.pop_front();
            if (rsp_out_word !== pw.word) report("out_word", rsp_out_word, pw.word);
            if (rsp_packet_end !== pw.last) report("packet_end", 32'(rsp_packet_end), 32'(pw.last));
            words_checked++;
         end
      end
   end

   initial begin
      #20ms;
      $display("FAILURE");
      $finish;
   end

   initial begin
      req_type directed [$];
      req_type r;
      int p, i;

      reset = 1'b1;
      req_push = 1'b0;
      req_payload_byte = '0;
      req_frame_start = 1'b0;
      req_stream_select = 1'b0;
      req_keyframe = 1'b0;
      req_pts = '0;
      req_dts = '0;
      req_frame_length = '0;
      rsp_pop = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      idle_en = 1'b1;
      hold_req = 1'b0;
      hold_left = 0;
      pid_by_stream[0] = VIDEO_PID_RESET;
      pid_by_stream[1] = AUDIO_PID_RESET;
      sid_by_stream[0] = VIDEO_SID_RESET;
      sid_by_stream[1] = AUDIO_SID_RESET;
      stamp_delay = '0;
      cont_count[0] = '0;
      cont_count[1] = '0;
      pkt_pos = 0;
      frame_left = '0;
      frame_stream = 1'b0;
      word_bytes = '0;
      word_fill = 0;
      repeat (6) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // One-byte video frame right after reset: sync, start flag, default PID,
      // stuffing adaptation field and continuity count one.
      directed.push_back('{8'h00, 1, 0, 0, 33'd0, 33'd0, 24'd1, 1, 32'h4741_0031});
      directed.push_back('{8'hff, 0, 1, 1, '1, '1, '1, 0, '0});           // stray byte
      directed.push_back('{8'h5a, 1, 1, 1, '1, 33'd0, 24'd0, 0, '0});     // empty start
      directed.push_back('{8'haa, 1, 1, 1, '1, 33'd0, 24'd1, 1, 32'h4741_0131});
      directed.push_back('{8'h01, 1, 0, 1, 33'd5, 33'd5, 24'd3, 0, '0});
      directed.push_back('{8'h02, 1, 1, 1, '1, '1, '1, 0, '0});           // early start
      directed.push_back('{8'h03, 0, 0, 0, 33'd0, 33'd0, 24'd0, 0, '0});
      directed.push_back('{8'h80, 1, 1, 0, '1, '1, 24'd2, 0, '0});
      directed.push_back('{8'h7f, 0, 0, 0, 33'd0, 33'd0, 24'd0, 0, '0});
      directed.push_back('{8'h55, 1, 0, 0, 33'd1, 33'd2, 24'd1, 0, '0});
      directed.push_back('{8'h11, 1, 0, 1, 33'd0, '1, 24'd1, 0, '0});
      foreach (directed[i]) send_request(directed[i]);
      drain();

      for (p = 0; p < 4; p++) begin
         case (p)
            1: begin
               csr_write(CSR_VIDEO_PID, 33'd0);
               csr_write(CSR_AUDIO_PID, 33'h1fff);
               csr_write(CSR_VIDEO_SID, 33'd0);
               csr_write(CSR_AUDIO_SID, 33'hff);
               csr_write(CSR_TS_DELAY, '1);
               csr_write(CSR_SPARE_INDEX, '1);
            end
            2: begin
               csr_write(CSR_VIDEO_PID, rand33());
               csr_write(CSR_AUDIO_PID, rand33());
               csr_write(CSR_VIDEO_SID, rand33());
               csr_write(CSR_AUDIO_SID, rand33());
               csr_write(CSR_TS_DELAY, rand33());
            end
            3: begin
               csr_write(CSR_VIDEO_PID, 33'h1fff);
               csr_write(CSR_AUDIO_PID, 33'd0);
               csr_write(CSR_VIDEO_SID, 33'hff);
               csr_write(CSR_AUDIO_SID, 33'd0);
               csr_write(CSR_TS_DELAY, 33'd90000);
            end
            default: ;
         endcase
         if (p > 0) @(negedge clock) csr_we <= 1'b0;
         // No idling at all during the first register setting written over the CSRs.
         idle_en = (p != 1);
         if (p == 2) hold_req = 1'b1;
         random_frames(40);
         drain();
      end

      // A frame longer than the PES length field can hold; only its start is sent.
      r = rand_fields(1'b1);
      r.len = '1;
      r.key = 1'b1;
      send_request(r);
      for (i = 1; i < 40; i++) send_request(rand_fields(1'b0));
      drain();

      $display("Covered %0d requests in %0d frames under %0d register writes;",
               requests_sent, frames_sent, csr_writes);
      $display("checked %0d packet words with %0d mismatches.", words_checked, errors);
      if (errors == 0 && expected_words.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> ts_pes_packetizer_top.f
sv/tspes_pkg.sv
sv/tspes_fifo.sv
sv/tspes_front.sv
sv/tspes_back.sv
sv/ts_pes_packetizer_top.sv
sv/tspes_checker.sv
dv/tb_ts_pes_packetizer_top.sv
